// ===== sv/ddpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ddpp_pkg;

  // Element and sum width, fixed by the item format
  localparam int unsigned DATA_W = 32;
  // Elements per vector, one lane each
  localparam int unsigned LANES = 4;
  // Slots per group; the last one goes straight to the output
  localparam int unsigned SLOTS = 4;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  // Default fraction bits of the fixed-point format
  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [2*DATA_W-1:0] prod_t;

  // Stage load enables handed to each lane
  typedef struct packed {
    logic ld_mul;
    logic ld_clamp;
  } lane_ctl_t;

  // Add two sums and clamp to the signed 32-bit range
  function automatic data_t sat_add(input data_t a, input data_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      sat_add = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat_add = s[DATA_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/ddpp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input channel: three vectors per item
interface ddpp_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] f_0;
  logic signed [31:0] f_1;
  logic signed [31:0] f_2;
  logic signed [31:0] f_3;
  logic signed [31:0] v_0;
  logic signed [31:0] v_1;
  logic signed [31:0] v_2;
  logic signed [31:0] v_3;
  logic signed [31:0] c_0;
  logic signed [31:0] c_1;
  logic signed [31:0] c_2;
  logic signed [31:0] c_3;

  modport source (
    output valid, f_0, f_1, f_2, f_3, v_0, v_1, v_2, v_3, c_0, c_1, c_2, c_3,
    input  ready
  );
  modport sink (
    input  valid, f_0, f_1, f_2, f_3, v_0, v_1, v_2, v_3, c_0, c_1, c_2, c_3,
    output ready
  );
endinterface

// Output channel: eight packed sums per item
interface ddpp_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] f_sum_0;
  logic signed [31:0] f_sum_1;
  logic signed [31:0] f_sum_2;
  logic signed [31:0] f_sum_3;
  logic signed [31:0] v_sum_0;
  logic signed [31:0] v_sum_1;
  logic signed [31:0] v_sum_2;
  logic signed [31:0] v_sum_3;

  modport source (
    output valid, f_sum_0, f_sum_1, f_sum_2, f_sum_3,
    output v_sum_0, v_sum_1, v_sum_2, v_sum_3,
    input  ready
  );
  modport sink (
    input  valid, f_sum_0, f_sum_1, f_sum_2, f_sum_3,
    input  v_sum_0, v_sum_1, v_sum_2, v_sum_3,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/ddpp_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One element position: F*C and V*C, then scale and clamp
module ddpp_lane #(
  parameter int unsigned FRAC_BITS = ddpp_pkg::FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  ddpp_pkg::lane_ctl_t ctl,
  input  ddpp_pkg::data_t     f,
  input  ddpp_pkg::data_t     v,
  input  ddpp_pkg::data_t     c,
  output ddpp_pkg::data_t     f_prod,
  output ddpp_pkg::data_t     v_prod
);

  localparam int unsigned DW = ddpp_pkg::DATA_W;

  ddpp_pkg::prod_t f_mul;
  ddpp_pkg::prod_t v_mul;
  ddpp_pkg::prod_t f_shr;
  ddpp_pkg::prod_t v_shr;
  ddpp_pkg::data_t f_clamp;
  ddpp_pkg::data_t v_clamp;

  // Register full-width products
  always_ff @(posedge clk) begin
    if (ctl.ld_mul) begin
      f_mul <= f * c;
      v_mul <= v * c;
    end
  end

  // Drop fraction bits, rounding toward minus infinity
  assign f_shr = f_mul >>> FRAC_BITS;
  assign v_shr = v_mul >>> FRAC_BITS;

  // Clamp to the signed 32-bit range
  always_comb begin
    if (f_shr[2*DW-1:DW-1] != {(DW+1){f_shr[2*DW-1]}}) begin
      f_clamp = f_shr[2*DW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      f_clamp = f_shr[DW-1:0];
    end
    if (v_shr[2*DW-1:DW-1] != {(DW+1){v_shr[2*DW-1]}}) begin
      v_clamp = v_shr[2*DW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      v_clamp = v_shr[DW-1:0];
    end
  end

  // Hold clamped products for the merge stage
  always_ff @(posedge clk) begin
    if (ctl.ld_clamp) begin
      f_prod <= f_clamp;
      v_prod <= v_clamp;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ddpp_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Adder trees over the lanes, slot buffers and the output register
module ddpp_merge (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  ddpp_pkg::data_t    f_prod [ddpp_pkg::LANES],
  input  ddpp_pkg::data_t    v_prod [ddpp_pkg::LANES],
  ddpp_out_if.source         res
);

  localparam int unsigned NBUF = ddpp_pkg::SLOTS - 1;

  logic                            pair_valid;
  ddpp_pkg::data_t                 f_pair [2];
  ddpp_pkg::data_t                 v_pair [2];
  ddpp_pkg::data_t                 f_total;
  ddpp_pkg::data_t                 v_total;
  logic [ddpp_pkg::SLOT_W-1:0]     slot;
  logic                            last;
  logic                            fin_ok;
  logic                            fin;
  ddpp_pkg::data_t                 f_buf [NBUF];
  ddpp_pkg::data_t                 v_buf [NBUF];
  logic                            out_valid;
  ddpp_pkg::data_t                 f_out [ddpp_pkg::SLOTS];
  ddpp_pkg::data_t                 v_out [ddpp_pkg::SLOTS];

  // Finish an item unless it closes a group and the output is still full
  assign last     = (slot == ddpp_pkg::LAST_SLOT);
  assign fin_ok   = !last || !out_valid || res.ready;
  assign fin      = pair_valid && fin_ok;
  assign in_ready = !pair_valid || fin_ok;

  // First tree level
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (in_ready) begin
      pair_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_pair[0] <= ddpp_pkg::sat_add(f_prod[0], f_prod[1]);
      f_pair[1] <= ddpp_pkg::sat_add(f_prod[2], f_prod[3]);
      v_pair[0] <= ddpp_pkg::sat_add(v_prod[0], v_prod[1]);
      v_pair[1] <= ddpp_pkg::sat_add(v_prod[2], v_prod[3]);
    end
  end

  // Second tree level
  assign f_total = ddpp_pkg::sat_add(f_pair[0], f_pair[1]);
  assign v_total = ddpp_pkg::sat_add(v_pair[0], v_pair[1]);

  // Advance the slot count, wrapping at the group end
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else if (fin) begin
      slot <= slot + 1'b1;
    end
  end

  // Store the sums of the first slots of a group
  for (genvar j = 0; j < NBUF; j++) begin : g_buf
    always_ff @(posedge clk) begin
      if (fin && slot == ddpp_pkg::SLOT_W'(j)) begin
        f_buf[j] <= f_total;
        v_buf[j] <= v_total;
      end
    end
  end

  // Output register: load the whole group when its last item finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin && last) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && last) begin
      for (int j = 0; j < NBUF; j++) begin
        f_out[j] <= f_buf[j];
        v_out[j] <= v_buf[j];
      end
      f_out[NBUF] <= f_total;
      v_out[NBUF] <= v_total;
    end
  end

  assign res.valid   = out_valid;
  assign res.f_sum_0 = f_out[0];
  assign res.f_sum_1 = f_out[1];
  assign res.f_sum_2 = f_out[2];
  assign res.f_sum_3 = f_out[3];
  assign res.v_sum_0 = v_out[0];
  assign res.v_sum_1 = v_out[1];
  assign res.v_sum_2 = v_out[2];
  assign res.v_sum_3 = v_out[3];

endmodule

`default_nettype wire

// ===== sv/dual_dot_product_packer_top.sv =====
// A group's result is valid once its fourth item has passed the product, clamp, pair
// and output registers (products registered at the accepting edge, then scale and clamp,
// pair add, final add). Throughput: one item per cycle while the output takes results,
// set by the four lanes of two multipliers each; one result leaves for every four items.
// Reset (rst, synchronous): clears the stage valids, the slot count and the
// output valid; the slot buffers are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module dual_dot_product_packer_top #(
  parameter int unsigned FRAC_BITS = ddpp_pkg::FRAC_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst,
  ddpp_in_if.sink     vec,
  ddpp_out_if.source  sums
);

  localparam int unsigned L = ddpp_pkg::LANES;

  ddpp_pkg::data_t   f_in   [L];
  ddpp_pkg::data_t   v_in   [L];
  ddpp_pkg::data_t   c_in   [L];
  ddpp_pkg::data_t   f_prod [L];
  ddpp_pkg::data_t   v_prod [L];
  ddpp_pkg::lane_ctl_t lane_ctl;
  logic              mul_valid;
  logic              clamp_valid;
  logic              merge_ready;
  logic              clamp_ready;
  logic              mul_ready;

  // Gather vector elements by lane
  assign f_in[0] = vec.f_0;
  assign f_in[1] = vec.f_1;
  assign f_in[2] = vec.f_2;
  assign f_in[3] = vec.f_3;
  assign v_in[0] = vec.v_0;
  assign v_in[1] = vec.v_1;
  assign v_in[2] = vec.v_2;
  assign v_in[3] = vec.v_3;
  assign c_in[0] = vec.c_0;
  assign c_in[1] = vec.c_1;
  assign c_in[2] = vec.c_2;
  assign c_in[3] = vec.c_3;

  // Stage ready chain: a stage loads when empty or when it moves on
  assign clamp_ready = !clamp_valid || merge_ready;
  assign mul_ready   = !mul_valid || clamp_ready;
  assign vec.ready   = mul_ready;

  assign lane_ctl.ld_mul   = mul_ready && vec.valid;
  assign lane_ctl.ld_clamp = clamp_ready && mul_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid   <= 1'b0;
      clamp_valid <= 1'b0;
    end else begin
      if (mul_ready) begin
        mul_valid <= vec.valid;
      end
      if (clamp_ready) begin
        clamp_valid <= mul_valid;
      end
    end
  end

  for (genvar i = 0; i < L; i++) begin : g_lane
    ddpp_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .ctl    (lane_ctl),
      .f      (f_in[i]),
      .v      (v_in[i]),
      .c      (c_in[i]),
      .f_prod (f_prod[i]),
      .v_prod (v_prod[i])
    );
  end

  ddpp_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (clamp_valid),
    .in_ready (merge_ready),
    .f_prod   (f_prod),
    .v_prod   (v_prod),
    .res      (sums)
  );

endmodule

`default_nettype wire
